// ===== rtl/spbc_pkg.sv =====
// Shared types and constants for the servo position backlash controller.
package spbc_pkg;

  localparam int POSITION_BITS = 16;
  localparam int PULSE_BITS    = 12;
  localparam int SPAN_BITS     = PULSE_BITS + 1;
  localparam int WAIT_BITS     = 16;
  localparam int IDLE_BITS     = 24;
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 32;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [PULSE_BITS-1:0] PULSE_MAX = '1;

  localparam logic [REG_IDX_BITS-1:0] REG_MIN_PULSE    = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_PULSE    = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_POSITION = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SLACK_AMOUNT = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_SLACK_WAIT   = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_AUTO_IDLE    = 3'd5;

  localparam logic [PULSE_BITS-1:0]    RST_MIN_PULSE    = 12'd500;
  localparam logic [PULSE_BITS-1:0]    RST_MAX_PULSE    = 12'd2500;
  localparam logic [POSITION_BITS-1:0] RST_MAX_POSITION = 16'd1000;
  localparam logic [WAIT_BITS-1:0]     RST_SLACK_WAIT   = 16'd10000;

  localparam logic ACTION_TICK    = 1'b0;
  localparam logic ACTION_COMMAND = 1'b1;

  localparam logic [1:0] STATUS_TICK        = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED    = 2'd1;
  localparam logic [1:0] STATUS_ABOVE_MAX   = 2'd2;
  localparam logic [1:0] STATUS_BELOW_SLACK = 2'd3;

  typedef struct packed {
    logic                     action;
    logic [POSITION_BITS-1:0] target_position;
  } request_t;

  typedef struct packed {
    logic [PULSE_BITS-1:0]    pulse_us;
    logic                     pulse_written;
    logic                     output_enabled;
    logic                     pre_positioning;
    logic [1:0]               command_status;
    logic [POSITION_BITS-1:0] current_position;
  } result_t;

endpackage

// ===== rtl/spbc_pulse_unit.sv =====
// Pulse width unit: one registered multiply, then a bit-serial restoring divide.
module spbc_pulse_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [spbc_pkg::POSITION_BITS-1:0] pos,
  input  logic [spbc_pkg::PULSE_BITS-1:0]    min_pulse_us,
  input  logic [spbc_pkg::PULSE_BITS-1:0]    max_pulse_us,
  input  logic [spbc_pkg::POSITION_BITS-1:0] max_position,
  output logic                               done,
  output logic [spbc_pkg::PULSE_BITS-1:0]    pulse
);

  localparam int PW    = spbc_pkg::PULSE_BITS;
  localparam int POS_W = spbc_pkg::POSITION_BITS;
  localparam int PROD_W = POS_W + spbc_pkg::SPAN_BITS;
  localparam int REM_W  = POS_W + 1;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

  typedef enum logic [1:0] {U_IDLE, U_DIV, U_DONE} unit_state_t;

  unit_state_t                      state;
  logic [PROD_W-1:0]                quo;
  logic [REM_W-1:0]                 rem;
  logic [CNT_W-1:0]                 cnt;
  logic [spbc_pkg::SPAN_BITS-1:0]   span;
  logic [REM_W-1:0]                 divisor;
  logic [REM_W:0]                   shifted;
  logic                             fits;
  logic [REM_W-1:0]                 rem_next;
  logic [PW:0]                      sum;
  logic                             saturate;

  always_comb begin
    if (max_pulse_us >= min_pulse_us) begin
      span = {1'b0, max_pulse_us} + spbc_pkg::SPAN_BITS'(1) - {1'b0, min_pulse_us};
    end else begin
      span = '0;
    end
    divisor  = {1'b0, max_position} + REM_W'(1);
    shifted  = {rem, quo[PROD_W-1]};
    fits     = shifted >= {1'b0, divisor};
    if (fits) begin
      rem_next = REM_W'(shifted - {1'b0, divisor});
    end else begin
      rem_next = shifted[REM_W-1:0];
    end
    sum      = {1'b0, min_pulse_us} + {1'b0, quo[PW-1:0]};
    saturate = (|quo[PROD_W-1:PW]) | sum[PW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            quo   <= PROD_W'(pos * span);
            rem   <= '0;
            cnt   <= '0;
            state <= U_DIV;
          end
        end
        U_DIV: begin
          rem <= rem_next;
          quo <= {quo[PROD_W-2:0], fits};
          cnt <= cnt + CNT_W'(1);
          if (cnt == LAST_STEP) begin
            state <= U_DONE;
          end
        end
        U_DONE: begin
          pulse <= saturate ? spbc_pkg::PULSE_MAX : sum[PW-1:0];
          done  <= 1'b1;
          state <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/servo_position_backlash_controller.sv =====
// Servo position controller with backlash compensation and auto-idle.
//
//   channel  signals                              direction
//   req      req_valid, req_ready, req            request in: tick or position command
//   rsp      rsp_valid, rsp_ready, rsp            one result out per request
//   cfg      psel, penable, pwrite, paddr, pwdata  register access, prdata, pready
//
// A tick that writes no pulse goes from S_EVAL straight to S_SEND.
// A request that writes a pulse waits in S_PULSE for the 29-step serial divider
// in the pulse unit. The block takes one request at a time.
// Reset is synchronous; a stalled result holds in the output register while
// the next request is accepted and worked on.
module servo_position_backlash_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  spbc_pkg::request_t             req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output spbc_pkg::result_t              rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spbc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [spbc_pkg::DATA_BITS-1:0] pwdata,
  output logic [spbc_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);

  localparam int POS_W = spbc_pkg::POSITION_BITS;
  localparam int PW    = spbc_pkg::PULSE_BITS;
  localparam int WW    = spbc_pkg::WAIT_BITS;
  localparam int IW    = spbc_pkg::IDLE_BITS;
  localparam int DW    = spbc_pkg::DATA_BITS;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_PULSE, S_SEND} state_t;

  state_t state;
  spbc_pkg::request_t cur;

  logic [PW-1:0]    min_pulse_us;
  logic [PW-1:0]    max_pulse_us;
  logic [POS_W-1:0] max_position;
  logic [POS_W-1:0] slack_amount;
  logic [WW-1:0]    slack_wait_ms;
  logic [IW-1:0]    auto_idle_ms;

  logic [POS_W-1:0] final_position;
  logic [PW-1:0]    driven_pulse;
  logic             line_enabled;
  logic             holding_overshoot;
  logic [WW-1:0]    overshoot_countdown;
  logic [IW-1:0]    idle_countdown;
  logic             idle_armed;
  logic             written;
  logic [1:0]       status;

  logic [POS_W-1:0] final_position_next;
  logic             line_enabled_next;
  logic             holding_overshoot_next;
  logic [WW-1:0]    overshoot_countdown_next;
  logic [IW-1:0]    idle_countdown_next;
  logic             idle_armed_next;
  logic [1:0]       status_next;
  logic             need_pulse;
  logic [POS_W-1:0] pulse_pos;

  logic                        cfg_write;
  logic [spbc_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic                        pu_start;
  logic                        pu_done;
  logic [PW-1:0]               pu_pulse;

  assign req_ready = (state == S_IDLE);
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_idx   = paddr[spbc_pkg::ADDR_BITS-1:2];
  assign pu_start  = (state == S_EVAL) & need_pulse;

  always_comb begin
    case (reg_idx)
      spbc_pkg::REG_MIN_PULSE:    prdata = DW'(min_pulse_us);
      spbc_pkg::REG_MAX_PULSE:    prdata = DW'(max_pulse_us);
      spbc_pkg::REG_MAX_POSITION: prdata = DW'(max_position);
      spbc_pkg::REG_SLACK_AMOUNT: prdata = DW'(slack_amount);
      spbc_pkg::REG_SLACK_WAIT:   prdata = DW'(slack_wait_ms);
      spbc_pkg::REG_AUTO_IDLE:    prdata = DW'(auto_idle_ms);
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    final_position_next      = final_position;
    line_enabled_next        = line_enabled;
    holding_overshoot_next   = holding_overshoot;
    overshoot_countdown_next = overshoot_countdown;
    idle_countdown_next      = idle_countdown;
    idle_armed_next          = idle_armed;
    status_next              = spbc_pkg::STATUS_TICK;
    need_pulse               = 1'b0;
    pulse_pos                = final_position;
    if (cur.action == spbc_pkg::ACTION_TICK) begin
      if (idle_armed) begin
        idle_countdown_next = idle_countdown - IW'(1);
        if (idle_countdown_next == '0) begin
          idle_armed_next   = 1'b0;
          line_enabled_next = 1'b0;
        end
      end
      if (holding_overshoot) begin
        overshoot_countdown_next = overshoot_countdown - WW'(1);
        if (overshoot_countdown_next == '0) begin
          holding_overshoot_next = 1'b0;
          need_pulse             = 1'b1;
          if (auto_idle_ms != '0) begin
            idle_countdown_next = auto_idle_ms;
            idle_armed_next     = 1'b1;
          end
        end
      end
    end else if (cur.target_position > max_position) begin
      status_next = spbc_pkg::STATUS_ABOVE_MAX;
    end else if ((slack_amount != '0) && (cur.target_position < slack_amount)) begin
      status_next = spbc_pkg::STATUS_BELOW_SLACK;
    end else begin
      status_next              = spbc_pkg::STATUS_ACCEPTED;
      line_enabled_next        = 1'b1;
      holding_overshoot_next   = 1'b0;
      overshoot_countdown_next = '0;
      idle_armed_next          = 1'b0;
      idle_countdown_next      = '0;
      if ((cur.target_position < final_position) && (slack_amount != '0)) begin
        holding_overshoot_next   = 1'b1;
        overshoot_countdown_next = (slack_wait_ms != '0) ? slack_wait_ms : WW'(1);
        pulse_pos                = cur.target_position - slack_amount;
      end else begin
        pulse_pos = cur.target_position;
        if (auto_idle_ms != '0) begin
          idle_countdown_next = auto_idle_ms;
          idle_armed_next     = 1'b1;
        end
      end
      final_position_next = cur.target_position;
      need_pulse          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      rsp_valid           <= 1'b0;
      min_pulse_us        <= spbc_pkg::RST_MIN_PULSE;
      max_pulse_us        <= spbc_pkg::RST_MAX_PULSE;
      max_position        <= spbc_pkg::RST_MAX_POSITION;
      slack_amount        <= '0;
      slack_wait_ms       <= spbc_pkg::RST_SLACK_WAIT;
      auto_idle_ms        <= '0;
      final_position      <= '0;
      driven_pulse        <= '0;
      line_enabled        <= 1'b1;
      holding_overshoot   <= 1'b0;
      overshoot_countdown <= '0;
      idle_countdown      <= '0;
      idle_armed          <= 1'b0;
      written             <= 1'b0;
      status              <= spbc_pkg::STATUS_TICK;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_SEND)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          final_position      <= final_position_next;
          line_enabled        <= line_enabled_next;
          holding_overshoot   <= holding_overshoot_next;
          overshoot_countdown <= overshoot_countdown_next;
          idle_countdown      <= idle_countdown_next;
          idle_armed          <= idle_armed_next;
          status              <= status_next;
          written             <= need_pulse;
          state               <= need_pulse ? S_PULSE : S_SEND;
        end
        S_PULSE: begin
          if (pu_done) begin
            driven_pulse <= pu_pulse;
            state        <= S_SEND;
          end
        end
        S_SEND: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.pulse_us         <= driven_pulse;
            rsp.pulse_written    <= written;
            rsp.output_enabled   <= line_enabled;
            rsp.pre_positioning  <= holding_overshoot;
            rsp.command_status   <= status;
            rsp.current_position <= final_position;
            rsp_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_write) begin
        case (reg_idx)
          spbc_pkg::REG_MIN_PULSE:    min_pulse_us  <= pwdata[PW-1:0];
          spbc_pkg::REG_MAX_PULSE:    max_pulse_us  <= pwdata[PW-1:0];
          spbc_pkg::REG_MAX_POSITION: max_position  <= pwdata[POS_W-1:0];
          spbc_pkg::REG_SLACK_AMOUNT: slack_amount  <= pwdata[POS_W-1:0];
          spbc_pkg::REG_SLACK_WAIT:   slack_wait_ms <= pwdata[WW-1:0];
          spbc_pkg::REG_AUTO_IDLE:    auto_idle_ms  <= pwdata[IW-1:0];
          default: ;
        endcase
        if (line_enabled && ((reg_idx == spbc_pkg::REG_MIN_PULSE) ||
                             (reg_idx == spbc_pkg::REG_MAX_PULSE) ||
                             (reg_idx == spbc_pkg::REG_MAX_POSITION) ||
                             (reg_idx == spbc_pkg::REG_AUTO_IDLE))) begin
          idle_armed     <= 1'b0;
          idle_countdown <= '0;
        end
      end
    end
  end

  spbc_pulse_unit u_pulse (
    .clk          (clk),
    .rst          (rst),
    .start        (pu_start),
    .pos          (pulse_pos),
    .min_pulse_us (min_pulse_us),
    .max_pulse_us (max_pulse_us),
    .max_position (max_position),
    .done         (pu_done),
    .pulse        (pu_pulse)
  );

endmodule
